// ===== sv/ghrp_pkg.sv =====
package ghrp_pkg;

  // Pool geometry
  localparam int POOL_SLOTS = 8;
  localparam int SLOT_W     = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(POOL_SLOTS - 1);

  // Field widths
  localparam int OP_W  = 3;
  localparam int IDX_W = 8;
  localparam int GEN_W = 32;
  localparam int REF_W = 16;

  localparam logic [REF_W-1:0] REF_LIMIT = '1;

  // Opcodes
  localparam logic [OP_W-1:0] OP_ACQUIRE = 3'd0;
  localparam logic [OP_W-1:0] OP_FINISH  = 3'd1;
  localparam logic [OP_W-1:0] OP_RESOLVE = 3'd2;
  localparam logic [OP_W-1:0] OP_RETAIN  = 3'd3;
  localparam logic [OP_W-1:0] OP_RELEASE = 3'd4;

  // Sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_STEP
  } state_t;

  // One slot of the pool
  typedef struct packed {
    logic [GEN_W-1:0] gen;
    logic [REF_W-1:0] refs;
    logic             cleanup;
    logic             filling;
    logic             kind;
  } slot_t;

  // Decision of the slot unit for one visited slot
  typedef struct packed {
    logic  wr_en;
    slot_t wr_data;
    logic  ok;
    logic  hit;
  } alu_res_t;

endpackage

// ===== sv/ghrp_store.sv =====
module ghrp_store (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [ghrp_pkg::SLOT_W-1:0] addr,
  input  logic                      wr_en,
  input  ghrp_pkg::slot_t           wr_data,
  output ghrp_pkg::slot_t           rd_data
);
  import ghrp_pkg::*;

  slot_t slots [POOL_SLOTS];

  // Slot registers, cleared on reset; one access address shared by read and write
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < POOL_SLOTS; i++) begin
        slots[i] <= '0;
      end
    end else if (wr_en) begin
      slots[addr] <= wr_data;
    end
  end

  assign rd_data = slots[addr];

endmodule

// ===== sv/ghrp_alu.sv =====
module ghrp_alu (
  input  logic [ghrp_pkg::OP_W-1:0]  op,
  input  logic                       kind,
  input  logic [ghrp_pkg::GEN_W-1:0] gen,
  input  logic                       in_range,
  input  ghrp_pkg::slot_t            slot,
  output ghrp_pkg::alu_res_t         res
);
  import ghrp_pkg::*;

  logic             live;
  logic             reclaim;
  logic             dec;
  logic [REF_W-1:0] refs_sum;
  logic [GEN_W-1:0] gen_bump;
  slot_t            base;

  // Shared arithmetic: one reference adder, one generation incrementer
  assign dec      = (op == OP_RELEASE);
  assign refs_sum = slot.refs + (dec ? {REF_W{1'b1}} : REF_W'(1));
  assign gen_bump = (slot.gen == {GEN_W{1'b1}}) ? GEN_W'(1) : slot.gen + GEN_W'(1);

  assign live = (gen != '0) && in_range && (slot.gen == gen) && (slot.refs != '0);

  // Reclaim view of the slot during an acquire scan
  assign reclaim = slot.cleanup && (slot.refs == '0);

  always_comb begin
    base = slot;
    if (reclaim) begin
      base.cleanup = 1'b0;
      base.filling = 1'b0;
      base.kind    = 1'b0;
    end
    res         = '0;
    res.wr_data = slot;
    case (op)
      OP_ACQUIRE: begin
        res.wr_en   = reclaim;
        res.wr_data = base;
        if ((base.refs == '0) && !base.cleanup && !base.filling) begin
          res.wr_en           = 1'b1;
          res.wr_data.gen     = gen_bump;
          res.wr_data.kind    = kind;
          res.wr_data.filling = 1'b1;
          res.wr_data.refs    = REF_W'(1);
          res.ok              = 1'b1;
          res.hit             = 1'b1;
        end
      end
      OP_FINISH: begin
        if (live && slot.filling) begin
          res.wr_en           = 1'b1;
          res.wr_data.filling = 1'b0;
          res.ok              = 1'b1;
        end
      end
      OP_RESOLVE: begin
        res.ok = live && !slot.filling && (slot.kind == kind);
      end
      OP_RETAIN: begin
        if (live && !slot.filling && !slot.cleanup && (slot.refs != REF_LIMIT)) begin
          res.wr_en        = 1'b1;
          res.wr_data.refs = refs_sum;
          res.ok           = 1'b1;
        end
      end
      OP_RELEASE: begin
        if (gen == '0) begin
          res.ok = 1'b1;
        end else if (live && !slot.cleanup) begin
          res.wr_en        = 1'b1;
          res.wr_data.refs = refs_sum;
          // last reference gone: park the slot until an acquire reclaims it
          if (slot.refs == REF_W'(1)) begin
            res.wr_data.cleanup = 1'b1;
          end
          res.ok = 1'b1;
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

// ===== sv/generation_handle_refcount_pool.sv =====
// Sequence: finish, resolve, retain, release and unused opcodes are registered, evaluated
//   in ST_STEP and give their registered word on done; acquire visits one slot per cycle.
// Throughput: a new start is taken in the cycle done is high; one slot unit evaluated
//   per cycle sets the pace (an acquire scan stops at the first free slot or the last slot).
// Reset: rst (synchronous) clears all slots to generation 0, no references, directory.
// The receiver cannot stall: done is high for one cycle only; the word holds until the next result.
module generation_handle_refcount_pool (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [ghrp_pkg::OP_W-1:0]  opcode,
  input  logic                       kind,
  input  logic [ghrp_pkg::IDX_W-1:0] handle_index,
  input  logic [ghrp_pkg::GEN_W-1:0] handle_generation,
  output logic                       done,
  output logic                       ok,
  output logic [ghrp_pkg::IDX_W-1:0] out_index,
  output logic [ghrp_pkg::GEN_W-1:0] out_generation
);
  import ghrp_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [OP_W-1:0]   op_q;
  logic              kind_q;
  logic [GEN_W-1:0]  gen_q;
  logic              in_range;
  logic [SLOT_W-1:0] addr;
  logic [SLOT_W-1:0] addr_next;
  logic              finish;
  slot_t             rd_data;
  alu_res_t          res;

  // Slot storage and the shared slot unit
  ghrp_store u_store (
    .clk     (clk),
    .rst     (rst),
    .addr    (addr),
    .wr_en   (res.wr_en && (state == ST_STEP)),
    .wr_data (res.wr_data),
    .rd_data (rd_data)
  );

  ghrp_alu u_alu (
    .op       (op_q),
    .kind     (kind_q),
    .gen      (gen_q),
    .in_range (in_range),
    .slot     (rd_data),
    .res      (res)
  );

  assign busy = (state != ST_IDLE);

  // Sequencer: next state and scan pointer
  always_comb begin
    state_next = state;
    addr_next  = addr;
    finish     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_STEP;
          addr_next  = (opcode == OP_ACQUIRE) ? '0 : handle_index[SLOT_W-1:0];
        end
      end
      ST_STEP: begin
        if ((op_q != OP_ACQUIRE) || res.hit || (addr == LAST_SLOT)) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
        end else begin
          addr_next = addr + SLOT_W'(1);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= finish;
    end
  end

  // Command word and scan pointer
  always_ff @(posedge clk) begin
    addr <= addr_next;
    if (start && !busy) begin
      op_q     <= opcode;
      kind_q   <= kind;
      gen_q    <= handle_generation;
      in_range <= ({1'b0, handle_index} < (IDX_W + 1)'(POOL_SLOTS));
    end
  end

  // Result word
  always_ff @(posedge clk) begin
    if (finish) begin
      ok             <= res.ok;
      out_index      <= res.hit ? IDX_W'(addr) : '0;
      out_generation <= res.hit ? res.wr_data.gen : '0;
    end
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == ST_IDLE))
    else $error("result word while a command is still in progress");

  a_start_step: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == ST_STEP))
    else $error("accepted command did not start");

  a_single_step: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_STEP) && (op_q != OP_ACQUIRE)) |=> done)
    else $error("handle operation took more than one step");

  a_gen_needs_ok: assert property (@(posedge clk) disable iff (rst)
    (done && !ok) |-> ((out_generation == '0) && (out_index == '0)))
    else $error("refused command returned a handle");

  a_hit_gen_nonzero: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_STEP) && res.hit) |-> (res.wr_data.gen != '0))
    else $error("acquire handed out a null generation");
`endif

endmodule

// ===== bench/handle_pool_checker.sv =====
`timescale 1ns / 100ps

// Watches the command and result channels of the handle pool, keeps a
// shadow copy of every slot and scores each result word in order.
module handle_pool_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       busy,
  input  logic [ghrp_pkg::OP_W-1:0]  opcode,
  input  logic                       kind,
  input  logic [ghrp_pkg::IDX_W-1:0] handle_index,
  input  logic [ghrp_pkg::GEN_W-1:0] handle_generation,
  input  logic                       done,
  input  logic                       ok,
  input  logic [ghrp_pkg::IDX_W-1:0] out_index,
  input  logic [ghrp_pkg::GEN_W-1:0] out_generation,
  output int                         mismatches,
  output int                         pending_words
);
  import ghrp_pkg::*;

  typedef struct packed {
    logic             ok;
    logic [IDX_W-1:0] idx;
    logic [GEN_W-1:0] gen;
  } answer_t;

  // Shadow slot state
  logic [GEN_W-1:0] gen_q     [POOL_SLOTS];
  logic [REF_W-1:0] refs_q    [POOL_SLOTS];
  logic             cleanup_q [POOL_SLOTS];
  logic             filling_q [POOL_SLOTS];
  logic             kind_q    [POOL_SLOTS];

  answer_t expected_answers[$];
  answer_t want;

  function automatic void clear_slots();
    int i;
    for (i = 0; i < POOL_SLOTS; i++) begin
      gen_q[i]     = '0;
      refs_q[i]    = '0;
      cleanup_q[i] = 1'b0;
      filling_q[i] = 1'b0;
      kind_q[i]    = '0;
    end
  endfunction

  // Handle is nonzero, in range, matches the slot generation and still holds a reference
  function automatic logic handle_live(logic [IDX_W-1:0] idx, logic [GEN_W-1:0] g);
    logic [SLOT_W-1:0] s;
    s = idx[SLOT_W-1:0];
    return g != '0 && idx < POOL_SLOTS && gen_q[s] == g && refs_q[s] != '0;
  endfunction

  // Applies one command word to the shadow pool and returns its answer
  function automatic answer_t apply_handle_op(logic [OP_W-1:0] op, logic k,
                                              logic [IDX_W-1:0] idx,
                                              logic [GEN_W-1:0] g);
    answer_t           a;
    logic [SLOT_W-1:0] s;
    logic [GEN_W-1:0]  next_gen;
    logic              found;
    int                i;
    a     = '0;
    s     = idx[SLOT_W-1:0];
    found = 1'b0;
    case (op)
      OP_ACQUIRE: begin
        for (i = 0; i < POOL_SLOTS; i++) begin
          if (!found) begin
            // reclaim dead slots on the way; kind goes back to directory
            if (cleanup_q[i] && refs_q[i] == '0) begin
              cleanup_q[i] = 1'b0;
              filling_q[i] = 1'b0;
              kind_q[i]    = '0;
            end
            if (refs_q[i] == '0 && !cleanup_q[i] && !filling_q[i]) begin
              next_gen = gen_q[i] + 1'b1;
              if (next_gen == '0) next_gen = GEN_W'(1);
              gen_q[i]     = next_gen;
              kind_q[i]    = k;
              filling_q[i] = 1'b1;
              refs_q[i]    = REF_W'(1);
              a.ok  = 1'b1;
              a.idx = IDX_W'(i);
              a.gen = next_gen;
              found = 1'b1;
            end
          end
        end
      end
      OP_FINISH: begin
        if (handle_live(idx, g) && filling_q[s]) begin
          filling_q[s] = 1'b0;
          a.ok = 1'b1;
        end
      end
      OP_RESOLVE: begin
        a.ok = handle_live(idx, g) && !filling_q[s] && kind_q[s] == k;
      end
      OP_RETAIN: begin
        if (handle_live(idx, g) && !filling_q[s] && !cleanup_q[s] &&
            refs_q[s] < REF_LIMIT) begin
          refs_q[s] = refs_q[s] + 1'b1;
          a.ok = 1'b1;
        end
      end
      OP_RELEASE: begin
        if (g == '0) begin
          a.ok = 1'b1;
        end else if (handle_live(idx, g) && !cleanup_q[s]) begin
          refs_q[s] = refs_q[s] - 1'b1;
          if (refs_q[s] == '0) cleanup_q[s] = 1'b1;
          a.ok = 1'b1;
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  // Score result words first, then record the newly accepted command word
  always @(posedge clk) begin
    if (rst) begin
      clear_slots();
      expected_answers.delete();
      mismatches = 0;
    end else begin
      if (done) begin
        if (expected_answers.size() == 0) begin
          $error("unexpected result word: ok=%0d index=%0d generation=%0h",
                 ok, out_index, out_generation);
          mismatches++;
        end else begin
          want = expected_answers.pop_front();
          if (ok !== want.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, ok);
            mismatches++;
          end
          if (out_index !== want.idx) begin
            $error("out_index: expected %0d, got %0d", want.idx, out_index);
            mismatches++;
          end
          if (out_generation !== want.gen) begin
            $error("out_generation: expected %0h, got %0h", want.gen, out_generation);
            mismatches++;
          end
        end
      end
      if (start && !busy)
        expected_answers = {expected_answers,
                            apply_handle_op(opcode, kind, handle_index,
                                            handle_generation)};
    end
    pending_words = expected_answers.size();
  end

endmodule

// ===== bench/tb_generation_handle_refcount_pool.sv =====
`timescale 1ns / 100ps

module tb_generation_handle_refcount_pool;
  import ghrp_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED_FIRST = OP_RELEASE + 1'b1;
  localparam logic [OP_W-1:0] OP_UNUSED_LAST  = '1;
  localparam logic            KIND_DIRECTORY  = 1'b0;
  localparam logic            KIND_FILE_CHUNK = 1'b1;
  localparam int RANDOM_WORDS   = 800;
  localparam int RETAIN_BURST   = 3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 2 * POOL_SLOTS + 4;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [GEN_W-1:0] gen;
  } grant_t;

  logic             clk;
  logic             rst               = 1'b1;
  logic             start             = 1'b0;
  logic             busy;
  logic [OP_W-1:0]  opcode            = OP_ACQUIRE;
  logic             kind              = KIND_DIRECTORY;
  logic [IDX_W-1:0] handle_index      = '0;
  logic [GEN_W-1:0] handle_generation = '0;
  logic             done;
  logic             ok;
  logic [IDX_W-1:0] out_index;
  logic [GEN_W-1:0] out_generation;
  int               mismatches;
  int               pending_words;
  int               idle_cycles = 0;

  grant_t granted_handles[$];

  generation_handle_refcount_pool dut (.*);

  handle_pool_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Collect granted handles so later words can reuse them
  always @(negedge clk) begin
    if (!rst && done && out_generation != '0) begin
      granted_handles = {granted_handles, grant_t'{idx: out_index, gen: out_generation}};
      if (granted_handles.size() > 24) void'(granted_handles.pop_front());
    end
  end

  // Watchdog: no command or result word moving for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Random pick among the opcodes the block does not define
  function automatic logic [OP_W-1:0] OP_OPCODE_PICK();
    return OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
  endfunction

  // Present one command word; returns at the edge that accepts it
  task automatic drive_word(input logic [OP_W-1:0] op, input logic k,
                            input logic [IDX_W-1:0] idx,
                            input logic [GEN_W-1:0] gen, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start             <= 1'b1;
    opcode            <= op;
    kind              <= k;
    handle_index      <= idx;
    handle_generation <= gen;
    do @(posedge clk); while (busy);
  endtask

  // Hold off until every outstanding result word has come back
  task automatic drain_words();
    start <= 1'b0;
    @(negedge clk);
    while (pending_words != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    int               n;
    int               i;
    int               r;
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx;
    logic [GEN_W-1:0] gen;
    grant_t           g;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: slot 0 gets generation 1 on the first acquire
    drive_word(OP_ACQUIRE, KIND_FILE_CHUNK, '0, '0, 0);
    for (op = OP_UNUSED_FIRST; ; op++) begin
      drive_word(op, KIND_FILE_CHUNK, '0, GEN_W'(1), pick_gap());
      if (op == OP_UNUSED_LAST) break;
    end
    // null handle: release succeeds, the rest refuse
    drive_word(OP_RELEASE, KIND_DIRECTORY, '0, '0, 0);
    drive_word(OP_FINISH,  KIND_DIRECTORY, '0, '0, 0);
    drive_word(OP_RESOLVE, KIND_DIRECTORY, '0, '0, 0);
    drive_word(OP_RETAIN,  KIND_DIRECTORY, '0, '0, 0);
    // still filling: resolve and retain refuse
    drive_word(OP_RESOLVE, KIND_FILE_CHUNK, '0, GEN_W'(1), 0);
    drive_word(OP_RETAIN,  KIND_FILE_CHUNK, '0, GEN_W'(1), 0);
    drive_word(OP_FINISH,  KIND_FILE_CHUNK, '0, GEN_W'(1), 0);
    drive_word(OP_FINISH,  KIND_FILE_CHUNK, '0, GEN_W'(1), 0);
    // kind mismatch, then a good resolve
    drive_word(OP_RESOLVE, KIND_DIRECTORY,  '0, GEN_W'(1), 0);
    drive_word(OP_RESOLVE, KIND_FILE_CHUNK, '0, GEN_W'(1), 0);
    // index out of range (aliases slot 0 in the low bits), stale generation
    drive_word(OP_RESOLVE, KIND_FILE_CHUNK, IDX_W'(POOL_SLOTS), GEN_W'(1), 0);
    drive_word(OP_RESOLVE, KIND_FILE_CHUNK, '1, GEN_W'(1), 0);
    drive_word(OP_RESOLVE, KIND_FILE_CHUNK, '0, '1, 0);
    // fill the pool, then one acquire too many
    for (i = 0; i < POOL_SLOTS; i++)
      drive_word(OP_ACQUIRE, logic'(i[0]), '0, '0, pick_gap());
    drain_words();

    // A few extra references on slot 0, then release down to cleanup;
    // the release after the last reference is refused
    for (i = 0; i < RETAIN_BURST; i++)
      drive_word(OP_RETAIN, KIND_FILE_CHUNK, '0, GEN_W'(1), 0);
    for (i = 0; i <= RETAIN_BURST + 1; i++)
      drive_word(OP_RELEASE, KIND_FILE_CHUNK, '0, GEN_W'(1), 0);
    // slot is cleanup pending with no references
    drive_word(OP_RETAIN,  KIND_FILE_CHUNK, '0, GEN_W'(1), 0);
    drive_word(OP_RESOLVE, KIND_FILE_CHUNK, '0, GEN_W'(1), 0);
    // reclaim on the acquire scan, generation moves to 2
    drive_word(OP_ACQUIRE, KIND_DIRECTORY, '0, '0, 0);
    drain_words();

    // Random traffic, mostly on granted handles
    // (a generation wrap needs 2^32 acquires of one slot and is not reached)
    for (n = 0; n < RANDOM_WORDS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 22) op = OP_ACQUIRE;
      else if (r < 40) op = OP_FINISH;
      else if (r < 58) op = OP_RESOLVE;
      else if (r < 76) op = OP_RETAIN;
      else if (r < 96) op = OP_RELEASE;
      else op = OP_OPCODE_PICK();

      if (granted_handles.size() > 0 && $urandom_range(0, 9) < 8) begin
        g   = granted_handles[$urandom_range(0, granted_handles.size() - 1)];
        idx = g.idx;
        gen = g.gen;
      end else begin
        idx = IDX_W'($urandom_range(0, POOL_SLOTS - 1));
        gen = GEN_W'($urandom_range(0, 3));
      end
      // corrupt a few handles
      case ($urandom_range(0, 19))
        0: gen = $urandom();
        1: gen = gen ^ (GEN_W'(1) << $urandom_range(0, GEN_W - 1));
        2: gen = '0;
        3: idx = IDX_W'($urandom_range(0, 255));
        default: ;
      endcase

      drive_word(op, logic'($urandom_range(0, 1)), idx, gen,
                 ((n / 50) % 4 == 3) ? 0 : pick_gap());
      if (n % 200 == 199) drain_words();
    end

    drain_words();
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0 && pending_words == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
